>>> hdl/glm_pkg.sv
// Shared types and constants for the gated nearest-landmark association block.
`default_nettype none

package glm_pkg;

  // Fixed field widths
  localparam int unsigned POS_W      = 20;
  localparam int unsigned CONF_W     = 16;
  localparam int unsigned GATE_W     = 19;
  localparam int unsigned GATE2_W    = 2 * GATE_W;
  localparam int unsigned DIFF_W     = POS_W + 1;
  localparam int unsigned D2_W       = 2 * DIFF_W;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IDX_OUT_W  = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [GATE_W-1:0]  ASSOC_GATE_RST = GATE_W'(512);
  localparam logic [CONF_W-1:0]  CONF_GATE_RST  = CONF_W'(32768);
  localparam logic [GATE2_W-1:0] GATE2_RST      = GATE2_W'(262144);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_ASSOC  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NOT_ASSESSED = 2'd0,
    ST_NEW          = 2'd1,
    ST_MATCHED      = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ASSOC_GATE = 8'd0,
    CFG_CONF_GATE  = 8'd1
  } cfg_reg_e;

  // One landmark or observation position
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } pos_t;

  // Gate settings handed from the register bank to the datapath
  typedef struct packed {
    logic [GATE2_W-1:0] gate2;
    logic [CONF_W-1:0]  conf_gate;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/glm_if.sv
// Handshake channels: input items, result items and register writes.
`default_nettype none

interface glm_in_if;
  logic                             valid;
  logic                             ready;
  logic [glm_pkg::OP_W-1:0]         operation;
  logic signed [glm_pkg::POS_W-1:0] pos_x;
  logic signed [glm_pkg::POS_W-1:0] pos_y;
  logic [glm_pkg::CONF_W-1:0]       confidence;

  modport source (output valid, operation, pos_x, pos_y, confidence, input ready);
  modport sink   (input valid, operation, pos_x, pos_y, confidence, output ready);
endinterface

interface glm_out_if;
  logic                            valid;
  logic                            ready;
  glm_pkg::status_e                status;
  logic [glm_pkg::IDX_OUT_W-1:0]   landmark_index;

  modport source (output valid, status, landmark_index, input ready);
  modport sink   (input valid, status, landmark_index, output ready);
endinterface

interface glm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [glm_pkg::CFG_IDX_W-1:0]    index;
  logic [glm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/glm_cfg.sv
// Register bank for the two gates, with the squared association gate kept ready.
`default_nettype none

module glm_cfg (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  glm_cfg_if.sink        cfg_i,
  output glm_pkg::cfg_t  cfg_o
);

  logic [glm_pkg::GATE_W-1:0]  assoc_gate_q;
  logic [glm_pkg::CONF_W-1:0]  conf_gate_q;
  logic [glm_pkg::GATE2_W-1:0] gate2_q;

  assign cfg_i.ready = 1'b1;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assoc_gate_q <= glm_pkg::ASSOC_GATE_RST;
      conf_gate_q  <= glm_pkg::CONF_GATE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        glm_pkg::CFG_ASSOC_GATE: assoc_gate_q <= cfg_i.data[glm_pkg::GATE_W-1:0];
        glm_pkg::CFG_CONF_GATE:  conf_gate_q  <= cfg_i.data[glm_pkg::CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // Keep the squared gate in a register, so the decision compares squared values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate2_q <= glm_pkg::GATE2_RST;
    end else begin
      gate2_q <= glm_pkg::GATE2_W'(assoc_gate_q) * glm_pkg::GATE2_W'(assoc_gate_q);
    end
  end

  assign cfg_o.gate2     = gate2_q;
  assign cfg_o.conf_gate = conf_gate_q;

endmodule

`default_nettype wire

>>> hdl/glm_table.sv
// Landmark store: one write port, one read port with registered read data.
`default_nettype none

module glm_table #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [AddrW-1:0]    wr_addr_i,
  input  wire glm_pkg::pos_t       wr_data_i,
  input  wire logic                rd_en_i,
  input  wire logic [AddrW-1:0]    rd_addr_i,
  output glm_pkg::pos_t            rd_data_o
);

  glm_pkg::pos_t mem_q [Depth];
  glm_pkg::pos_t rd_data_q;

  // Write the appended landmark
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one landmark per cycle during a scan
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> hdl/glm_dist.sv
// Squared-distance pipeline: difference stage, square stage, then the sum.
`default_nettype none

module glm_dist #(
  parameter int unsigned IdxW = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        vld_i,
  input  wire logic [IdxW-1:0]             idx_i,
  input  wire glm_pkg::pos_t               obs_i,
  input  wire glm_pkg::pos_t               lm_i,
  output logic                             vld_o,
  output logic [IdxW-1:0]                  idx_o,
  output logic [glm_pkg::D2_W-1:0]         d2_o,
  output logic                             busy_o
);

  logic                               s1_vld_q, s2_vld_q;
  logic [IdxW-1:0]                    s1_idx_q, s2_idx_q;
  logic signed [glm_pkg::DIFF_W-1:0]  dx_q, dy_q;
  logic signed [glm_pkg::D2_W-1:0]    sqx_q, sqy_q;

  // Hold valid flags of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  // Stage 1: coordinate differences
  always_ff @(posedge clk_i) begin
    s1_idx_q <= idx_i;
    dx_q     <= glm_pkg::DIFF_W'(obs_i.x) - glm_pkg::DIFF_W'(lm_i.x);
    dy_q     <= glm_pkg::DIFF_W'(obs_i.y) - glm_pkg::DIFF_W'(lm_i.y);
  end

  // Stage 2: squares
  always_ff @(posedge clk_i) begin
    s2_idx_q <= s1_idx_q;
    sqx_q    <= glm_pkg::D2_W'(dx_q) * glm_pkg::D2_W'(dx_q);
    sqy_q    <= glm_pkg::D2_W'(dy_q) * glm_pkg::D2_W'(dy_q);
  end

  // Sum is non-negative and fits without overflow
  assign d2_o   = unsigned'(sqx_q) + unsigned'(sqy_q);
  assign vld_o  = s2_vld_q;
  assign idx_o  = s2_idx_q;
  assign busy_o = s1_vld_q | s2_vld_q;

endmodule

`default_nettype wire

>>> hdl/gated_nearest_landmark_association.sv
// Top level: landmark table control, nearest-landmark scan and gated decision.
`default_nettype none

// Keeps up to MAX_LANDMARKS landmark positions in a single-port-read memory.
// Clear and append items give no result; an append to a full table is
// dropped, as is operation code 3. An associate item walks the stored
// landmarks one memory read per cycle through a four-stage squared-distance
// pipeline (read, difference, square, sum and compare), so its result is
// loaded into the output register once the scan and pipeline have drained,
// later if the previous result is still waiting; the next item is taken the
// cycle after. Ties keep the lowest index. The result is "not assessed"
// below the confidence gate, "matched" with the index (low 8 bits) when the
// squared distance is strictly under the squared association gate, otherwise
// "new landmark". Gates may only be written while no item is in progress.
module gated_nearest_landmark_association #(
  parameter int unsigned MAX_LANDMARKS = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  glm_in_if.sink     in_i,
  glm_out_if.source  res_o,
  glm_cfg_if.sink    cfg_i
);

  localparam int unsigned IdxW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_LANDMARKS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LANDMARKS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [CntW-1:0]                 count_q;
  logic [CntW-1:0]                 scan_q;
  glm_pkg::pos_t                   obs_q;
  logic [glm_pkg::CONF_W-1:0]      conf_q;
  logic                            have_q;
  logic [glm_pkg::D2_W-1:0]        best_d2_q;
  logic [IdxW-1:0]                 best_idx_q;
  logic                            rd_vld_q;
  logic [IdxW-1:0]                 rd_idx_q;
  logic                            out_vld_q;
  glm_pkg::status_e                out_status_q;
  logic [glm_pkg::IDX_OUT_W-1:0]   out_idx_q;

  glm_pkg::cfg_t                   cfg;
  glm_pkg::pos_t                   in_pos;
  glm_pkg::pos_t                   rd_data;
  logic                            accept;
  logic                            do_append;
  logic                            issue;
  logic                            dist_vld;
  logic [IdxW-1:0]                 dist_idx;
  logic [glm_pkg::D2_W-1:0]        dist_d2;
  logic                            dist_busy;
  logic                            out_free;
  logic                            load_out;
  glm_pkg::status_e                status;
  logic [glm_pkg::IDX_OUT_W-1:0]   idx_out;

  glm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign in_pos.x  = in_i.pos_x;
  assign in_pos.y  = in_i.pos_y;
  assign accept    = in_i.valid && in_i.ready;
  assign do_append = accept && (in_i.operation == glm_pkg::OP_APPEND) && (count_q < MaxCnt);
  // Writes happen only in idle and reads only while scanning: no overlap
  assign issue     = (state_q == S_SCAN) && (scan_q < count_q);

  glm_table #(
    .Depth (MAX_LANDMARKS),
    .AddrW (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (do_append),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (in_pos),
    .rd_en_i   (issue),
    .rd_addr_i (scan_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  glm_dist #(
    .IdxW (IdxW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .idx_i  (rd_idx_q),
    .obs_i  (obs_q),
    .lm_i   (rd_data),
    .vld_o  (dist_vld),
    .idx_o  (dist_idx),
    .d2_o   (dist_d2),
    .busy_o (dist_busy)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign out_free   = !out_vld_q || res_o.ready;
  assign load_out   = (state_q == S_DONE) && out_free;

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_i.operation == glm_pkg::OP_ASSOC)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !dist_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Clear and append update the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept && (in_i.operation == glm_pkg::OP_CLEAR)) begin
      count_q <= '0;
    end else if (do_append) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // Capture the observation when any item is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      obs_q  <= in_pos;
      conf_q <= in_i.confidence;
    end
  end

  // Step the read address and tag the read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (accept) begin
        scan_q <= '0;
      end else if (issue) begin
        scan_q <= scan_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q[IdxW-1:0];
  end

  // Keep the first least distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (accept) begin
      have_q <= 1'b0;
    end else if (dist_vld) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_vld && (!have_q || (dist_d2 < best_d2_q))) begin
      best_d2_q  <= dist_d2;
      best_idx_q <= dist_idx;
    end
  end

  // Gate decision
  always_comb begin
    if (conf_q < cfg.conf_gate) begin
      status  = glm_pkg::ST_NOT_ASSESSED;
      idx_out = '0;
    end else if (have_q && (best_d2_q < glm_pkg::D2_W'(cfg.gate2))) begin
      status  = glm_pkg::ST_MATCHED;
      idx_out = glm_pkg::IDX_OUT_W'(best_idx_q);
    end else begin
      status  = glm_pkg::ST_NEW;
      idx_out = '0;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status;
      out_idx_q    <= idx_out;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.status         = out_status_q;
  assign res_o.landmark_index = out_idx_q;

endmodule

`default_nettype wire
